// File: rtl/jbe_pkg.sv
// jbe_pkg: shared types, constants and helpers of the jpeg block entropy encoder
`default_nettype none
package jbe_pkg;

  localparam int COEFS_PER_BLOCK = 64;
  localparam int AC_SYMBOLS      = 256;
  localparam int DC_SYMBOLS      = 12;
  localparam int DC_DEPTH        = 2 * DC_SYMBOLS;
  localparam int AC_DEPTH        = 2 * AC_SYMBOLS;
  localparam int DC_ADDR_W       = $clog2(DC_DEPTH);
  localparam int AC_ADDR_W       = $clog2(AC_DEPTH);
  localparam int MAX_CODE_LEN    = 16;

  localparam logic [7:0]  SYM_ZRL   = 8'hF0;
  localparam logic [7:0]  SYM_EOB   = 8'h00;
  localparam logic signed [10:0] PRED_INIT = 11'sd128;

  localparam logic [1:0] COMP_LUMA = 2'd0;
  localparam logic [1:0] COMP_CR   = 2'd2;
  localparam logic [1:0] COMP_BAD  = 2'd3;

  typedef enum logic [1:0] {
    CMD_COEF  = 2'd0,
    CMD_TABLE = 2'd1,
    CMD_FRAME = 2'd2,
    CMD_EMPTY = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    REG_MAX_LEVEL = 1'b0,
    REG_MIN_LEVEL = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [4:0]  len;
    logic [15:0] code;
  } entry_t;

  typedef struct packed {
    logic                 dc_we;
    logic [DC_ADDR_W-1:0] dc_addr;
    logic                 ac_we;
    logic [AC_ADDR_W-1:0] ac_addr;
    entry_t               data;
  } tbl_wr_t;

  typedef struct packed {
    logic [DC_ADDR_W-1:0] dc_addr;
    logic [AC_ADDR_W-1:0] ac_addr0;
    logic [AC_ADDR_W-1:0] ac_addr1;
  } tbl_rd_t;

  typedef struct packed {
    logic [3:0]  nb;
    logic [10:0] bits;
  } amp_t;

  // size category and amplitude bits, ones complement for negatives
  function automatic amp_t amp_of(input logic signed [12:0] v);
    logic [12:0] mag;
    logic [10:0] mask;
    amp_t        r;
    mag  = v[12] ? 13'(-v) : 13'(v);
    r.nb = 4'd0;
    for (int i = 0; i < 11; i++) begin
      if (mag[i]) r.nb = 4'(i + 1);
    end
    mask   = ~(11'h7FF << r.nb);
    r.bits = (v[12] ? ~mag[10:0] : mag[10:0]) & mask;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/jbe_tables.sv
// jbe_tables: dc and ac huffman code memories, one write port, registered reads
`default_nettype none
module jbe_tables (
  input  wire logic             clk,
  input  wire jbe_pkg::tbl_wr_t wr,
  input  wire logic             rd_en,
  input  wire jbe_pkg::tbl_rd_t rd,
  output jbe_pkg::entry_t       dc_q,
  output jbe_pkg::entry_t       ac_q0,
  output jbe_pkg::entry_t       ac_q1
);

  jbe_pkg::entry_t dc_mem [jbe_pkg::DC_DEPTH];
  jbe_pkg::entry_t ac_mem [jbe_pkg::AC_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.dc_we) begin
      dc_mem[wr.dc_addr] <= wr.data;
    end
    if (wr.ac_we) begin
      ac_mem[wr.ac_addr] <= wr.data;
    end
    if (rd_en) begin
      dc_q  <= dc_mem[rd.dc_addr];
      ac_q0 <= ac_mem[rd.ac_addr0];
      ac_q1 <= ac_mem[rd.ac_addr1];
    end
  end

endmodule
`default_nettype wire

// File: rtl/jpeg_block_entropy_encoder.sv
// a result goes through the table read and stage-one registers, then the output registers, to m_*
// throughput: one input item per cycle while m_tready is high; each extra result of
//   an item (zrl words after runs of 16 or more zeros, the second word of an empty
//   chroma block) holds the input back while the result expander drains it, up to four results
// reset clears block position, zero run, component, predictors (to 128) and clip
//   bounds; the code tables are not cleared and must be loaded before use
`default_nettype none
module jpeg_block_entropy_encoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // component[1:0], coefficient[12:2], table_select[14:13], table_index[22:15],
  // code_length[27:23], code_value[43:28], zero fill
  input  wire logic [47:0] s_tdata,
  // cmd[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // code_bits[15:0], huff_length[20:16], extra_bits[31:21], extra_length[35:32], zero fill
  output logic [39:0]      m_tdata,
  // block_end[0]
  output logic [0:0]       m_tuser,
  output logic             m_tlast
);

  typedef struct packed {
    logic [1:0]  n_pre;
    logic        pre_dc;
    logic        main_dc;
    logic [10:0] ext_bits;
    logic [3:0]  ext_len;
    logic        bend;
  } s1_t;

  localparam logic [jbe_pkg::DC_ADDR_W-1:0] DC_CHROMA_BASE =
    jbe_pkg::DC_ADDR_W'(jbe_pkg::DC_SYMBOLS);
  localparam logic [5:0] LAST_POS = 6'(jbe_pkg::COEFS_PER_BLOCK - 1);

  // input fields
  jbe_pkg::cmd_t      cmd;
  logic [1:0]         component;
  logic signed [10:0] coefficient;
  logic [1:0]         table_select;
  logic [7:0]         table_index;
  logic [4:0]         code_length;
  logic [15:0]        code_value;

  assign cmd          = jbe_pkg::cmd_t'(s_tuser);
  assign component    = s_tdata[1:0];
  assign coefficient  = s_tdata[12:2];
  assign table_select = s_tdata[14:13];
  assign table_index  = s_tdata[22:15];
  assign code_length  = s_tdata[27:23];
  assign code_value   = s_tdata[43:28];

  // state
  logic signed [10:0] max_level, min_level;
  logic signed [10:0] pred [3];
  logic [5:0]         zero_run, zero_run_next;
  logic [5:0]         pos, pos_next;
  logic [1:0]         block_comp, block_comp_next;

  logic               s1_valid;
  s1_t                s1, s1_next;
  logic               has_result;
  logic [1:0]         k;
  logic               load_out, s1_done, accept;

  logic [15:0]        out_code;
  logic [4:0]         out_len;
  logic [10:0]        out_ebits;
  logic [3:0]         out_elen;
  logic               out_bend, out_last, out_valid;

  jbe_pkg::tbl_wr_t   wr;
  jbe_pkg::tbl_rd_t   rd;
  jbe_pkg::entry_t    dc_q, ac_q0, ac_q1;

  // front end
  logic signed [10:0] coef_clip;
  logic [1:0]         comp_c;
  logic signed [12:0] diff;
  jbe_pkg::amp_t      amp_dc, amp_ac;
  logic               final_pos, ac_chroma;
  logic [4:0]         wlen;

  assign accept = s_tvalid && s_tready;

  always_comb begin
    if (coefficient > max_level) begin
      coef_clip = max_level;
    end else if (coefficient < min_level) begin
      coef_clip = min_level;
    end else begin
      coef_clip = coefficient;
    end
  end

  assign comp_c    = (component == jbe_pkg::COMP_BAD) ? jbe_pkg::COMP_CR : component;
  assign diff      = 13'(coef_clip) - 13'(pred[comp_c]);
  assign amp_dc    = jbe_pkg::amp_of(diff);
  assign amp_ac    = jbe_pkg::amp_of(13'(coef_clip));
  assign final_pos = (pos == LAST_POS);
  assign ac_chroma = (block_comp != jbe_pkg::COMP_LUMA);
  assign wlen      = (code_length > 5'(jbe_pkg::MAX_CODE_LEN)) ?
                     5'(jbe_pkg::MAX_CODE_LEN) : code_length;

  always_comb begin
    wr.dc_we   = 1'b0;
    wr.ac_we   = 1'b0;
    wr.dc_addr = (table_select[0] ? DC_CHROMA_BASE : '0) +
                 jbe_pkg::DC_ADDR_W'(table_index[3:0]);
    wr.ac_addr = {table_select[0], table_index};
    wr.data    = '{len: wlen, code: code_value};

    rd.dc_addr  = (comp_c != jbe_pkg::COMP_LUMA ? DC_CHROMA_BASE : '0) +
                  jbe_pkg::DC_ADDR_W'(amp_dc.nb);
    rd.ac_addr0 = {ac_chroma, zero_run[3:0], amp_ac.nb};
    rd.ac_addr1 = {ac_chroma, jbe_pkg::SYM_ZRL};

    zero_run_next   = zero_run;
    pos_next        = pos;
    block_comp_next = block_comp;
    has_result      = 1'b0;
    s1_next         = '{n_pre: 2'd0, pre_dc: 1'b0, main_dc: 1'b0,
                        ext_bits: 11'd0, ext_len: 4'd0, bend: 1'b0};

    case (cmd)
      jbe_pkg::CMD_TABLE: begin
        if (table_select[1]) begin
          wr.ac_we = accept;
        end else if (table_index < 8'(jbe_pkg::DC_SYMBOLS)) begin
          wr.dc_we = accept;
        end
      end
      jbe_pkg::CMD_FRAME: begin
        zero_run_next = '0;
        pos_next      = '0;
      end
      jbe_pkg::CMD_EMPTY: begin
        rd.dc_addr     = DC_CHROMA_BASE;
        rd.ac_addr0    = {1'b1, jbe_pkg::SYM_EOB};
        has_result     = 1'b1;
        s1_next.n_pre  = 2'd1;
        s1_next.pre_dc = 1'b1;
        s1_next.bend   = 1'b1;
      end
      default: begin
        pos_next = final_pos ? 6'd0 : pos + 6'd1;
        if (pos == 6'd0) begin
          block_comp_next  = comp_c;
          zero_run_next    = '0;
          has_result       = 1'b1;
          s1_next.main_dc  = 1'b1;
          s1_next.ext_bits = amp_dc.bits;
          s1_next.ext_len  = amp_dc.nb;
        end else if (coef_clip == 11'sd0) begin
          zero_run_next = zero_run + 6'd1;
          rd.ac_addr0   = {ac_chroma, jbe_pkg::SYM_EOB};
          has_result    = final_pos;
          s1_next.bend  = 1'b1;
        end else begin
          // one zrl word per full run of 16 zeros ahead of the run/size word
          zero_run_next    = '0;
          has_result       = 1'b1;
          s1_next.n_pre    = zero_run[5:4];
          s1_next.ext_bits = amp_ac.bits;
          s1_next.ext_len  = amp_ac.nb;
          s1_next.bend     = final_pos;
        end
      end
    endcase
  end

  jbe_tables u_tables (
    .clk   (clk),
    .wr    (wr),
    .rd_en (accept),
    .rd    (rd),
    .dc_q  (dc_q),
    .ac_q0 (ac_q0),
    .ac_q1 (ac_q1)
  );

  // result expander
  assign load_out = s1_valid && (!out_valid || m_tready);
  assign s1_done  = load_out && (k == s1.n_pre);
  assign s_tready = !s1_valid || s1_done;

  jbe_pkg::entry_t word;
  logic            is_pre;

  assign is_pre = (k < s1.n_pre);

  always_comb begin
    if (is_pre) begin
      word = s1.pre_dc ? dc_q : ac_q1;
    end else begin
      word = s1.main_dc ? dc_q : ac_q0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_level  <= 11'sd1023;
      min_level  <= -11'sd1023;
      pred[0]    <= jbe_pkg::PRED_INIT;
      pred[1]    <= jbe_pkg::PRED_INIT;
      pred[2]    <= jbe_pkg::PRED_INIT;
      zero_run   <= '0;
      pos        <= '0;
      block_comp <= jbe_pkg::COMP_LUMA;
      s1_valid   <= 1'b0;
      k          <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == jbe_pkg::REG_MAX_LEVEL) begin
          max_level <= cfg_data;
        end else begin
          min_level <= cfg_data;
        end
      end
      if (accept) begin
        zero_run   <= zero_run_next;
        pos        <= pos_next;
        block_comp <= block_comp_next;
        if (cmd == jbe_pkg::CMD_FRAME) begin
          pred[0] <= jbe_pkg::PRED_INIT;
          pred[1] <= jbe_pkg::PRED_INIT;
          pred[2] <= jbe_pkg::PRED_INIT;
        end else if (cmd == jbe_pkg::CMD_COEF && pos == 6'd0) begin
          pred[comp_c] <= coef_clip;
        end
      end
      if (s1_done || !s1_valid) begin
        s1_valid <= accept && has_result;
        k        <= '0;
      end else if (load_out) begin
        k <= k + 2'd1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
    if (load_out) begin
      out_code  <= word.code;
      out_len   <= word.len;
      out_ebits <= is_pre ? 11'd0 : s1.ext_bits;
      out_elen  <= is_pre ? 4'd0 : s1.ext_len;
      out_bend  <= is_pre ? 1'b0 : s1.bend;
      out_last  <= !is_pre;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_elen, out_ebits, out_len, out_code};
  assign m_tuser  = out_bend;
  assign m_tlast  = out_last;

endmodule
`default_nettype wire

// File: tb/jpeg_block_entropy_encoder_test.sv
// testbench of the jpeg block entropy encoder: table loads, clipping, dc/ac coding, back-pressure
module jpeg_block_entropy_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import jbe_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 10;

  localparam logic [1:0] TBL_DC_LUMA   = 2'd0;
  localparam logic [1:0] TBL_DC_CHROMA = 2'd1;
  localparam logic [1:0] TBL_AC_LUMA   = 2'd2;
  localparam logic [1:0] TBL_AC_CHROMA = 2'd3;
  localparam logic [1:0] COMP_CB       = 2'd1;

  typedef enum int {
    SHAPE_EOB_ONLY,
    SHAPE_MAX_RUN,
    SHAPE_DENSE,
    SHAPE_SPARSE,
    SHAPE_MIXED
  } shape_t;

  typedef struct packed {
    logic [15:0] code;
    logic [4:0]  len;
    logic [10:0] ebits;
    logic [3:0]  elen;
    logic        bend;
    logic        last;
  } code_word_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_MAX_LEVEL;
  logic [10:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = CMD_COEF;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;

  // predictor state
  entry_t     dc_tab [DC_DEPTH];
  entry_t     ac_tab [AC_DEPTH];
  bit         ac_loaded [AC_DEPTH];
  int         dc_pred [3] = '{128, 128, 128};
  int         zero_count = 0;
  int         coef_pos = 0;
  int         cur_comp = 0;
  int         clip_hi = 1023;
  int         clip_lo = -1023;
  code_word_t pending_words [$];

  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_len = 0;
  int         sent_items = 0;
  int         blocks_sent = 0;
  int         mismatches = 0;
  int         quiet_cycles = 0;
  code_word_t got_word;
  code_word_t want_word;

  jpeg_block_entropy_encoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // size category and amplitude bits, ones complement for negatives
  function automatic void amplitude(input int v, output int nb, output logic [10:0] bits);
    int mag;
    mag = (v < 0) ? -v : v;
    nb = 0;
    while (mag != 0) begin
      mag = mag >> 1;
      nb++;
    end
    bits = 11'(((v < 0) ? v - 1 : v) & ((1 << nb) - 1));
  endfunction

  function automatic code_word_t code_word(input entry_t e, input logic [10:0] eb,
                                           input int el, input logic be);
    code_word_t w;
    w.code  = e.code;
    w.len   = e.len;
    w.ebits = eb;
    w.elen  = 4'(el);
    w.bend  = be;
    w.last  = 1'b0;
    return w;
  endfunction

  task automatic predict_code_words(input cmd_t c, input logic [47:0] d);
    code_word_t  words [4];
    int          n;
    int          v;
    int          comp;
    int          diff;
    int          nb;
    int          base;
    int          clen;
    bit          at_end;
    logic [10:0] bits;
    entry_t      ent;
    n = 0;
    case (c)
      CMD_TABLE: begin
        clen = int'(d[27:23]);
        ent.len  = 5'((clen > MAX_CODE_LEN) ? MAX_CODE_LEN : clen);
        ent.code = d[43:28];
        if (d[14:13] == TBL_DC_LUMA || d[14:13] == TBL_DC_CHROMA) begin
          // dc symbols past the last category are dropped
          if (int'(d[22:15]) < DC_SYMBOLS)
            dc_tab[int'(d[13]) * DC_SYMBOLS + int'(d[22:15])] = ent;
        end else begin
          ac_tab[int'(d[13]) * AC_SYMBOLS + int'(d[22:15])] = ent;
          ac_loaded[int'(d[13]) * AC_SYMBOLS + int'(d[22:15])] = 1'b1;
        end
      end
      CMD_FRAME: begin
        dc_pred = '{128, 128, 128};
        zero_count = 0;
        coef_pos = 0;
      end
      CMD_EMPTY: begin
        words[0] = code_word(dc_tab[DC_SYMBOLS], 11'd0, 0, 1'b0);
        words[1] = code_word(ac_tab[AC_SYMBOLS + int'(SYM_EOB)], 11'd0, 0, 1'b1);
        n = 2;
      end
      default: begin
        v = int'($signed(d[12:2]));
        if (v > clip_hi) v = clip_hi;
        else if (v < clip_lo) v = clip_lo;
        at_end = (coef_pos == COEFS_PER_BLOCK - 1);
        if (coef_pos == 0) begin
          comp = (int'(d[1:0]) > 2) ? 2 : int'(d[1:0]);
          cur_comp = comp;
          diff = v - dc_pred[comp];
          amplitude(diff, nb, bits);
          if (nb >= DC_SYMBOLS) nb = DC_SYMBOLS - 1;
          words[0] = code_word(dc_tab[((comp != 0) ? DC_SYMBOLS : 0) + nb], bits, nb, 1'b0);
          n = 1;
          dc_pred[comp] = v;
          zero_count = 0;
        end else begin
          base = (cur_comp != 0) ? AC_SYMBOLS : 0;
          if (v == 0) begin
            zero_count = (zero_count + 1) & 63;
            if (at_end) begin
              words[0] = code_word(ac_tab[base + int'(SYM_EOB)], 11'd0, 0, 1'b1);
              n = 1;
            end
          end else begin
            while (zero_count >= 16 && n < 3) begin
              words[n] = code_word(ac_tab[base + int'(SYM_ZRL)], 11'd0, 0, 1'b0);
              n++;
              zero_count -= 16;
            end
            amplitude(v, nb, bits);
            words[n] = code_word(ac_tab[base + (((zero_count & 15) << 4) | (nb & 15))],
                                 bits, nb, at_end);
            n++;
            zero_count = 0;
          end
        end
        coef_pos = at_end ? 0 : coef_pos + 1;
      end
    endcase
    if (n > 0) words[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_words.push_back(words[i]);
  endtask

  // holds the item until its transfer, then books the expected code words
  task automatic send_item(input cmd_t c, input logic [47:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= c;
    do @(posedge clk); while (!s_tready);
    predict_code_words(c, d);
    sent_items++;
  endtask

  task automatic send_table(input logic [1:0] sel, input logic [7:0] idx,
                            input logic [4:0] clen, input logic [15:0] cval);
    send_item(CMD_TABLE, {4'h0, cval, clen, idx, sel, 11'($urandom), 2'($urandom)});
  endtask

  // run/size entries are loaded on first use so that no code word reads an empty entry
  task automatic load_ac_entry(input int idx);
    logic [1:0] sel;
    sel = (cur_comp != 0) ? TBL_AC_CHROMA : TBL_AC_LUMA;
    if (!ac_loaded[((cur_comp != 0) ? AC_SYMBOLS : 0) + idx])
      send_table(sel, 8'(idx), 5'($urandom), 16'($urandom));
  endtask

  task automatic send_coef(input logic [1:0] comp, input logic [10:0] coef);
    int          v;
    int          nb;
    logic [10:0] bits;
    v = int'($signed(coef));
    if (v > clip_hi) v = clip_hi;
    else if (v < clip_lo) v = clip_lo;
    if (coef_pos != 0 && v != 0) begin
      amplitude(v, nb, bits);
      load_ac_entry(((zero_count & 15) << 4) | nb);
    end
    send_item(CMD_COEF, {4'h0, 16'($urandom), 5'($urandom), 8'($urandom), 2'($urandom),
                         coef, comp});
  endtask

  task automatic send_ctrl(input cmd_t c);
    send_item(c, {4'h0, 44'({$urandom, $urandom})});
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    // items without results may still be in flight
    repeat (8) @(posedge clk);
  endtask

  task automatic write_clip(input int hi, input int lo);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_LEVEL;
    cfg_data  <= 11'(hi);
    @(posedge clk);
    clip_hi = hi;
    cfg_index <= REG_MIN_LEVEL;
    cfg_data  <= 11'(lo);
    @(posedge clk);
    clip_lo = lo;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [10:0] rand_level();
    case ($urandom_range(3))
      0:       return 11'($urandom);
      1:       return 11'(int'($urandom_range(40)) - 20);
      default: return 11'(int'($urandom_range(6)) - 3);
    endcase
  endfunction

  function automatic logic [10:0] rand_nonzero();
    logic [10:0] lvl;
    do lvl = rand_level(); while (lvl == 11'd0);
    return lvl;
  endfunction

  task automatic send_block(input shape_t shape);
    logic [1:0]  comp;
    logic [10:0] lvl;
    int          density;
    comp = 2'($urandom_range(3));
    case (shape)
      SHAPE_EOB_ONLY: density = 0;
      SHAPE_DENSE:    density = 75;
      SHAPE_SPARSE:   density = 12;
      default:        density = $urandom_range(50);
    endcase
    send_coef(comp, rand_level());
    for (int p = 1; p < COEFS_PER_BLOCK; p++) begin
      if (shape == SHAPE_MAX_RUN)
        lvl = (p == COEFS_PER_BLOCK - 1) ? rand_nonzero() : 11'd0;
      else
        lvl = ($urandom_range(99) < density) ? rand_nonzero() : 11'd0;
      // component is only read on the first coefficient
      send_coef(2'($urandom), lvl);
      if ($urandom_range(39) == 0) send_ctrl(CMD_EMPTY);
    end
  endtask

  task automatic test_table_load();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < DC_SYMBOLS; i++) begin
      send_table(TBL_DC_LUMA, 8'(i), 5'($urandom), 16'($urandom));
      send_table(TBL_DC_CHROMA, 8'(i), 5'($urandom), 16'($urandom));
    end
    send_table(TBL_AC_LUMA, SYM_EOB, 5'($urandom), 16'($urandom));
    send_table(TBL_AC_CHROMA, SYM_EOB, 5'($urandom), 16'($urandom));
    send_table(TBL_AC_LUMA, SYM_ZRL, 5'($urandom), 16'($urandom));
    send_table(TBL_AC_CHROMA, SYM_ZRL, 5'($urandom), 16'($urandom));
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 28;
    recv_idle_pct = 77;
    send_ctrl(CMD_FRAME);
    send_coef(COMP_LUMA, 11'sd1023);
    send_coef(COMP_LUMA, -11'sd1024);  // below the reset lower bound
    send_ctrl(CMD_EMPTY);              // in the middle of a block
    send_ctrl(CMD_FRAME);              // abandons the partial block
    send_coef(COMP_CB, -11'sd1024);
    send_ctrl(CMD_FRAME);
    send_coef(COMP_BAD, 11'sd0);       // component three acts as cr
    send_coef(COMP_LUMA, 11'sd1);
    send_ctrl(CMD_FRAME);
    send_table(TBL_DC_LUMA, 8'hFF, 5'd31, 16'hFFFF);
    send_table(TBL_DC_CHROMA, 8'(DC_SYMBOLS), 5'd5, 16'h1234);
    send_table(TBL_AC_CHROMA, 8'hFF, 5'd17, 16'h0000);
    send_table(TBL_DC_LUMA, 8'h00, 5'd0, 16'h0000);
    send_coef(COMP_LUMA, 11'sd128);    // zero difference after frame start
    send_coef(COMP_LUMA, -11'sd1);
    send_ctrl(CMD_EMPTY);
    send_ctrl(CMD_FRAME);
  endtask

  task automatic test_random_traffic(input int tx_idle, input int rx_idle, input int n_items);
    int first;
    int pick;
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    first = sent_items;
    while (sent_items - first < n_items) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        send_block(shape_t'(blocks_sent % 5));
        blocks_sent++;
      end else if (pick == 7) begin
        repeat ($urandom_range(40, 1)) send_coef(2'($urandom), rand_level());
        send_ctrl(CMD_FRAME);
      end else if (pick == 8) begin
        send_ctrl(CMD_EMPTY);
      end else begin
        send_table(2'($urandom), 8'($urandom), 5'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // receiver stalls while a dense block keeps coming
    hold_len = 250;
    send_block(SHAPE_DENSE);
    drain();
  endtask

  // receiver side, long hold-offs are counted here
  initial begin : rx_side
    int left;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        left = hold_len;
        hold_len = 0;
      end
      if (left > 0) begin
        left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_word = {m_tdata[15:0], m_tdata[20:16], m_tdata[31:21], m_tdata[35:32],
                  m_tuser[0], m_tlast};
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected code word: code %h len %0d ebits %h elen %0d bend %b last %b",
                   got_word.code, got_word.len, got_word.ebits, got_word.elen,
                   got_word.bend, got_word.last);
      end else begin
        want_word = pending_words.pop_front();
        if (got_word.code !== want_word.code || got_word.len !== want_word.len ||
            got_word.ebits !== want_word.ebits || got_word.elen !== want_word.elen ||
            got_word.bend !== want_word.bend || got_word.last !== want_word.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp: code %h len %0d ebits %h elen %0d bend %b last %b",
                     want_word.code, want_word.len, want_word.ebits, want_word.elen,
                     want_word.bend, want_word.last);
            $display("         got: code %h len %0d ebits %h elen %0d bend %b last %b",
                     got_word.code, got_word.len, got_word.ebits, got_word.elen,
                     got_word.bend, got_word.last);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** jpeg_block_entropy_encoder: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_load();
    test_directed_cases();
    write_clip(1023, -1024);
    test_random_traffic(28, 77, 60);
    write_clip(7, -12);
    test_random_traffic(77, 28, 60);
    begin : random_bounds
      int a;
      int b;
      a = int'($urandom_range(2047)) - 1024;
      b = int'($urandom_range(2047)) - 1024;
      write_clip((a > b) ? a : b, (a > b) ? b : a);
    end
    test_random_traffic(0, 0, 60);
    write_clip(-1024, 1023);
    test_backpressure();
    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("** jpeg_block_entropy_encoder: PASSED **");
    end else begin
      $display("** jpeg_block_entropy_encoder: FAILED **");
    end
    $finish;
  end

endmodule
